// ===== hdl/hwdr_pkg.sv =====
// Package for the heading-walk dead reckoning core: fixed-point constants,
// widths and the CORDIC arctangent table.
// No dependencies; used by heading_walk_dead_reckoning_core.
package hwdr_pkg;

    // Build-time sizing
    localparam int CORDIC_STEPS = 16;   // rotation steps per sine/cosine, 8..24
    localparam int MAX_REPEAT   = 1023; // cap on repeats per command, 1..65535

    localparam int TABLE_LEN = 24;
    localparam int STEP_W    = $clog2(TABLE_LEN);
    localparam int REP_W     = $clog2(MAX_REPEAT + 1);

    // Angles in 1/256 degree
    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;

    // CORDIC gain in Q30, snap threshold in 1/65536
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int SNAP_LIMIT      = 655;

    localparam int POS_W = 48;
    localparam int CRD_W = 34; // CORDIC x/y datapath, Q2.30 plus headroom
    localparam int ANG_W = 25; // CORDIC residual angle, 1/65536 degree
    localparam int TRG_W = 32; // clamped sine/cosine, Q30

    typedef logic signed [POS_W-1:0] pos_t;

    // atan(2^-i) in units of 1/65536 degree
    function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/heading_walk_dead_reckoning_core.sv =====
// Heading-walk dead reckoning core: turn/walk/repeat commands drive a
// heading and a saturating x,y position through a shared CORDIC step unit.
// Depends on hwdr_pkg.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, turn_angle,           | one command per transfer
//          | step_distance, repeat_count               |
//  out     | out_valid, out_ready, pos_x, pos_y,       | one position report per
//          | saturated                                 | command
//
// A transfer leads to S_REDUCE, which corrects an out-of-range turn; each of
// the n repeats (n the capped repeat count) runs S_HEAD, S_FOLD, CORDIC_STEPS
// rotations of the CORDIC step unit in S_ROT, then S_FIN, S_MULX, S_ADDX and
// S_ADDY; S_DONE reports. in_ready is high only while the sequencer is idle.
// Reset clears heading, position, the sticky flag and the output valid. A held
// report blocks only the second one, which waits in the final state.
module heading_walk_dead_reckoning_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [17:0]  turn_angle,
    input  logic        [15:0]  step_distance,
    input  logic        [9:0]   repeat_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [47:0]  pos_x,
    output logic signed [47:0]  pos_y,
    output logic                saturated
);

    localparam int STEP_W = hwdr_pkg::STEP_W;
    localparam int REP_W  = hwdr_pkg::REP_W;
    localparam int CRD_W  = hwdr_pkg::CRD_W;
    localparam int ANG_W  = hwdr_pkg::ANG_W;
    localparam int TRG_W  = hwdr_pkg::TRG_W;
    localparam int POS_W  = hwdr_pkg::POS_W;
    localparam int CNT_W  = (REP_W > 10) ? REP_W : 10;
    localparam int DLT_W  = POS_W - 14;

    localparam logic signed [18:0] FULL19  = 19'(hwdr_pkg::FULL_TURN);
    localparam logic        [17:0] FULL18  = 18'(hwdr_pkg::FULL_TURN);
    localparam logic signed [17:0] FULL_S  = 18'(hwdr_pkg::FULL_TURN);
    localparam logic signed [17:0] HALF_S  = 18'(hwdr_pkg::HALF_TURN);
    localparam logic signed [17:0] QUART_S = 18'(hwdr_pkg::QUARTER_TURN);
    localparam logic signed [CRD_W-1:0] GAIN  = CRD_W'(hwdr_pkg::CORDIC_GAIN_Q30);
    localparam logic signed [CRD_W-1:0] ONE_P = CRD_W'(64'sd1 <<< 30);
    localparam logic signed [CRD_W-1:0] ONE_N = -ONE_P;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(hwdr_pkg::CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0]  REP_CAP   = CNT_W'(hwdr_pkg::MAX_REPEAT);
    localparam hwdr_pkg::pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam hwdr_pkg::pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam hwdr_pkg::pos_t SNAP_P  = POS_W'(hwdr_pkg::SNAP_LIMIT);
    localparam hwdr_pkg::pos_t SNAP_N  = -SNAP_P;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REDUCE = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_FOLD   = 4'd3;
    localparam logic [3:0] S_ROT    = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_MULX   = 4'd6;
    localparam logic [3:0] S_ADDX   = 4'd7;
    localparam logic [3:0] S_ADDY   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    function automatic hwdr_pkg::pos_t snap_pos(input hwdr_pkg::pos_t v);
        if (v >= SNAP_N && v <= SNAP_P)
            return '0;
        return v;
    endfunction

    function automatic logic signed [TRG_W-1:0] clamp_q30(input logic signed [CRD_W-1:0] v);
        if (v > ONE_P)
            return TRG_W'(ONE_P);
        if (v < ONE_N)
            return TRG_W'(ONE_N);
        return TRG_W'(v);
    endfunction

    // Control state
    logic [3:0]            state_reg, state_next;
    logic [16:0]           heading_reg, heading_next;
    hwdr_pkg::pos_t        acc_x_reg, acc_x_next;
    hwdr_pkg::pos_t        acc_y_reg, acc_y_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [REP_W-1:0]      rep_reg, rep_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // Datapath registers
    logic signed [18:0]       turn_reg, turn_next;
    logic [15:0]              dist_reg, dist_next;
    logic signed [CRD_W-1:0]  x_reg, x_next;
    logic signed [CRD_W-1:0]  y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic                     neg_reg, neg_next;
    logic signed [TRG_W-1:0]  sin_reg, sin_next;
    logic signed [TRG_W-1:0]  cos_reg, cos_next;
    logic signed [POS_W-1:0]  prod_reg, prod_next;
    hwdr_pkg::pos_t           pos_x_reg, pos_x_next;
    hwdr_pkg::pos_t           pos_y_reg, pos_y_next;

    // Shared units
    logic [17:0]              head_sum;
    logic signed [17:0]       fold_a0;
    logic signed [17:0]       fold_a;
    logic                     fold_neg;
    logic signed [CRD_W-1:0]  x_shift;
    logic signed [CRD_W-1:0]  y_shift;
    logic signed [ANG_W-1:0]  atan_val;
    logic signed [TRG_W-1:0]  mul_op;
    logic signed [48:0]       mul_full;
    logic signed [POS_W-1:0]  rnd;
    logic signed [DLT_W-1:0]  delta;
    hwdr_pkg::pos_t           add_base;
    logic signed [POS_W:0]    add_sum;
    hwdr_pkg::pos_t           add_clamped;
    logic                     add_ovf;
    logic [CNT_W-1:0]         cnt_in;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign saturated = sat_reg;

    always_comb
    begin
        // Heading advance: both operands already in [0, 360)
        head_sum = {1'b0, heading_reg} + {1'b0, turn_reg[16:0]};

        // Fold the heading into [-90, 90] and note the sign flip
        fold_a0 = signed'({1'b0, heading_reg});
        if (fold_a0 > HALF_S)
            fold_a0 = fold_a0 - FULL_S;
        fold_neg = 1'b0;
        fold_a   = fold_a0;
        if (fold_a0 > QUART_S)
        begin
            fold_a   = fold_a0 - HALF_S;
            fold_neg = 1'b1;
        end
        else if (fold_a0 < -QUART_S)
        begin
            fold_a   = fold_a0 + HALF_S;
            fold_neg = 1'b1;
        end

        // CORDIC step: arithmetic shifts round toward minus infinity
        x_shift  = x_reg >>> step_reg;
        y_shift  = y_reg >>> step_reg;
        atan_val = signed'(ANG_W'(hwdr_pkg::atan_lut(step_reg)));

        // Shared multiplier: sine in MULX, cosine in ADDX
        mul_op   = (state_reg == S_MULX) ? sin_reg : cos_reg;
        mul_full = signed'({1'b0, dist_reg}) * mul_op;

        // Round half up, then the shared saturating accumulator adder
        rnd      = prod_reg + POS_W'(8192);
        delta    = DLT_W'(rnd >>> 14);
        add_base = (state_reg == S_ADDX) ? acc_x_reg : acc_y_reg;
        add_sum  = {add_base[POS_W-1], add_base} + (POS_W+1)'(delta);
        add_ovf  = add_sum[POS_W] != add_sum[POS_W-1];
        if (add_ovf)
            add_clamped = add_sum[POS_W] ? POS_MIN : POS_MAX;
        else
            add_clamped = add_sum[POS_W-1:0];

        cnt_in = CNT_W'(repeat_count);
    end

    always_comb
    begin
        state_next     = state_reg;
        heading_next   = heading_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        rep_next       = rep_reg;
        step_next      = step_reg;
        turn_next      = turn_reg;
        dist_next      = dist_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        neg_next       = neg_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        prod_next      = prod_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;

        // Drop the report once the consumer takes it
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    turn_next = 19'(turn_angle);
                    dist_next = step_distance;
                    rep_next  = (cnt_in > REP_CAP) ? REP_W'(REP_CAP) : REP_W'(cnt_in);
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                // Bring the turn into [0, 360), one correction a cycle
                if (turn_reg < 0)
                    turn_next = turn_reg + FULL19;
                else if (turn_reg >= FULL19)
                    turn_next = turn_reg - FULL19;
                else if (rep_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                heading_next = (head_sum >= FULL18) ? 17'(head_sum - FULL18) : head_sum[16:0];
                state_next   = S_FOLD;
            end
            S_FOLD:
            begin
                x_next     = GAIN;
                y_next     = '0;
                z_next     = ANG_W'(fold_a) <<< 8;
                neg_next   = fold_neg;
                step_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - y_shift;
                    y_next = y_reg + x_shift;
                    z_next = z_reg - atan_val;
                end
                else
                begin
                    x_next = x_reg + y_shift;
                    y_next = y_reg - x_shift;
                    z_next = z_reg + atan_val;
                end
                if (step_reg == LAST_STEP)
                    state_next = S_FIN;
                else
                    step_next = step_reg + 1'b1;
            end
            S_FIN:
            begin
                sin_next   = clamp_q30(neg_reg ? -y_reg : y_reg);
                cos_next   = clamp_q30(neg_reg ? -x_reg : x_reg);
                state_next = S_MULX;
            end
            S_MULX:
            begin
                prod_next  = mul_full[POS_W-1:0];
                state_next = S_ADDX;
            end
            S_ADDX:
            begin
                acc_x_next = add_clamped;
                if (add_ovf)
                    sat_next = 1'b1;
                prod_next  = mul_full[POS_W-1:0];
                state_next = S_ADDY;
            end
            S_ADDY:
            begin
                acc_y_next = add_clamped;
                if (add_ovf)
                    sat_next = 1'b1;
                rep_next = rep_reg - 1'b1;
                if (rep_reg == REP_W'(1))
                    state_next = S_DONE;
                else
                    state_next = S_HEAD;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    pos_x_next     = snap_pos(acc_x_reg);
                    pos_y_next     = snap_pos(acc_y_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heading_reg   <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rep_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            heading_reg   <= heading_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            rep_reg       <= rep_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        turn_reg  <= turn_next;
        dist_reg  <= dist_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        neg_reg   <= neg_next;
        sin_reg   <= sin_next;
        cos_reg   <= cos_next;
        prod_reg  <= prod_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
    end

endmodule
